### rtl/fsrla_pkg.sv
package fsrla_pkg;

    localparam int NUM_DESC   = 4;
    localparam int DESC_W     = 50;
    localparam int LEN_W      = 18;
    localparam int ADDR_W     = 32;
    localparam int CNT_W      = 9;
    localparam int REC_W      = 8;
    localparam int SIU_W      = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int RING_W     = 5;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SECTORS_IN_USE = 3'd0,
        REG_SECTOR_DESC_0  = 3'd1,
        REG_SECTOR_DESC_1  = 3'd2,
        REG_SECTOR_DESC_2  = 3'd3,
        REG_SECTOR_DESC_3  = 3'd4
    } reg_index_t;

    typedef enum logic {
        CMD_ERASE = 1'b0,
        CMD_WRITE = 1'b1
    } cmd_kind_t;

    // Configuration as seen by the front and back parts.
    typedef struct packed {
        logic [RING_W-1:0]                ring;
        logic [NUM_DESC-1:0][DESC_W-1:0]  desc;
    } cfg_t;

    // One classified record waiting in the queue.
    typedef struct packed {
        logic             valid;
        logic             too_long;
        logic [CNT_W-1:0] cnt;
    } item_t;

endpackage

### rtl/flash_sector_ring_log_appender.sv
// Channel   Direction  Handshake             Word
// input     in         in_valid / in_ready   record_len
// output    out        out_valid / out_ready cmd_kind, sector_sel, write_addr,
//                                            byte_count, too_long, last
// config    in         cfg_write             cfg_index, cfg_data
//
// A record that needs no erase and whose tail sector has room leaves the
// sequencer as a single write word; one that needs an erase leaves as the erase
// and the write words, one after the other through the single output register.
// Each tail advance is a separate step, at most 2 * MAX_SECTORS per record.
// Reset is asynchronous and clears head, tail, offsets and blank marks at once;
// there is no clearing pass. A stall at the output holds the sequencer, while
// the two-word queue behind the front keeps accepting records until it is full.
module flash_sector_ring_log_appender #(
    parameter int MAX_SECTORS = 4,
    parameter int OFFSET_BITS = 18
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [fsrla_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fsrla_pkg::DESC_W-1:0]     cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [fsrla_pkg::REC_W-1:0]      record_len,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             cmd_kind,
    output logic [1:0]                       sector_sel,
    output logic [fsrla_pkg::ADDR_W-1:0]     write_addr,
    output logic [fsrla_pkg::CNT_W-1:0]      byte_count,
    output logic                             too_long,
    output logic                             last
);
    import fsrla_pkg::*;

    logic [SIU_W-1:0]                siu_reg;
    logic [NUM_DESC-1:0][DESC_W-1:0] desc_reg;
    logic [RING_W-1:0]               siu_ext;
    logic [RING_W-1:0]               ring_size;
    cfg_t                            cfg;
    item_t                           q_head;
    logic                            q_pop;

    // Register writes. Indexes past the last descriptor are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            siu_reg  <= SIU_W'(4);
            desc_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SECTORS_IN_USE: siu_reg     <= cfg_data[SIU_W-1:0];
                REG_SECTOR_DESC_0:  desc_reg[0] <= cfg_data;
                REG_SECTOR_DESC_1:  desc_reg[1] <= cfg_data;
                REG_SECTOR_DESC_2:  desc_reg[2] <= cfg_data;
                REG_SECTOR_DESC_3:  desc_reg[3] <= cfg_data;
                default:            ;
            endcase
        end
    end

    // The ring size is clamped to one sector at least and MAX_SECTORS at most.
    assign siu_ext = RING_W'(siu_reg);
    always_comb
    begin
        if (siu_ext == '0)
        begin
            ring_size = RING_W'(1);
        end
        else if (siu_ext > RING_W'(MAX_SECTORS))
        begin
            ring_size = RING_W'(MAX_SECTORS);
        end
        else
        begin
            ring_size = siu_ext;
        end
    end
    assign cfg = '{ring: ring_size, desc: desc_reg};

    // The front tags records that fit no sector and queues them.
    fsrla_front #(
        .MAX_SECTORS (MAX_SECTORS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .record_len (record_len),
        .pop        (q_pop),
        .head       (q_head)
    );

    // The back walks the tail, issues erases and writes, and owns the ring state.
    fsrla_back #(
        .MAX_SECTORS (MAX_SECTORS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .head       (q_head),
        .pop        (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .cmd_kind   (cmd_kind),
        .sector_sel (sector_sel),
        .write_addr (write_addr),
        .byte_count (byte_count),
        .too_long   (too_long),
        .last       (last)
    );

endmodule

### rtl/fsrla_front.sv
module fsrla_front #(
    parameter int MAX_SECTORS = 4
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  fsrla_pkg::cfg_t          cfg,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [fsrla_pkg::REC_W-1:0] record_len,
    input  logic                     pop,
    output fsrla_pkg::item_t         head
);
    import fsrla_pkg::*;

    logic [1:0][CNT_W:0] entry_reg, entry_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic       wr_ptr_reg, wr_ptr_next;
    logic [1:0] count_reg, count_next;
    logic [CNT_W-1:0] cnt;
    logic       any_fit;
    logic       push;

    assign cnt      = CNT_W'(record_len) + CNT_W'(1);
    assign in_ready = (count_reg != 2'd2);
    assign push     = in_valid && in_ready;

    // A record is too long when it fits no sector of the ring at offset zero.
    always_comb
    begin
        any_fit = 1'b0;
        for (int i = 0; i < NUM_DESC; i++)
        begin
            if (i < MAX_SECTORS && RING_W'(i) < cfg.ring &&
                LEN_W'(cnt) < cfg.desc[i][DESC_W-1:ADDR_W])
            begin
                any_fit = 1'b1;
            end
        end
    end

    always_comb
    begin
        entry_next  = entry_reg;
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            entry_next[wr_ptr_reg] = {!any_fit, cnt};
            wr_ptr_next = !wr_ptr_reg;
        end
        if (pop)
        begin
            rd_ptr_next = !rd_ptr_reg;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push && pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    assign head.valid    = (count_reg != 2'd0);
    assign head.too_long = entry_reg[rd_ptr_reg][CNT_W];
    assign head.cnt      = entry_reg[rd_ptr_reg][CNT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

### rtl/fsrla_back.sv
module fsrla_back #(
    parameter int MAX_SECTORS = 4,
    parameter int OFFSET_BITS = 18
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  fsrla_pkg::cfg_t              cfg,
    input  fsrla_pkg::item_t             head,
    output logic                         pop,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         cmd_kind,
    output logic [1:0]                   sector_sel,
    output logic [fsrla_pkg::ADDR_W-1:0] write_addr,
    output logic [fsrla_pkg::CNT_W-1:0]  byte_count,
    output logic                         too_long,
    output logic                         last
);
    import fsrla_pkg::*;

    localparam int IW     = (MAX_SECTORS > 1) ? $clog2(MAX_SECTORS) : 1;
    localparam int SELW   = (IW > 2) ? IW : 2;
    localparam int FW     = ((OFFSET_BITS > LEN_W) ? OFFSET_BITS : LEN_W) + 1;
    localparam int LIMIT  = 2 * MAX_SECTORS;
    localparam int AW     = $clog2(LIMIT + 1);

    typedef enum logic {
        ST_CHECK,
        ST_WRITE
    } state_t;

    state_t state_reg, state_next;
    logic [IW-1:0] tail_reg, tail_next;
    logic [IW-1:0] head_reg, head_next;
    logic [MAX_SECTORS-1:0][OFFSET_BITS-1:0] offset_reg, offset_next;
    logic [MAX_SECTORS-1:0] blank_reg, blank_next;
    logic [AW-1:0] adv_reg, adv_next;

    logic              out_valid_reg, out_valid_next;
    logic              kind_reg, kind_next;
    logic [1:0]        sel_reg, sel_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              too_long_reg, too_long_next;
    logic              last_reg, last_next;

    logic [DESC_W-1:0]      cur_desc;
    logic [OFFSET_BITS-1:0] cur_off;
    logic [FW-1:0]          end_pos;
    logic                   fits;
    logic [RING_W-1:0]      nt_wide, nh_wide;
    logic [IW-1:0]          nt, nh;
    logic [SELW-1:0]        tail_ext;
    logic                   can_load;

    always_comb
    begin
        cur_desc = '0;
        for (int i = 0; i < NUM_DESC; i++)
        begin
            if (i < MAX_SECTORS && RING_W'(tail_reg) == RING_W'(i))
            begin
                cur_desc = cfg.desc[i];
            end
        end
    end

    assign cur_off  = offset_reg[tail_reg];
    assign end_pos  = FW'(cur_off) + FW'(head.cnt);
    assign fits     = end_pos < FW'(cur_desc[DESC_W-1:ADDR_W]);
    assign tail_ext = SELW'(tail_reg);

    // Next tail and, when the tail catches the head, the next head.
    assign nt_wide = RING_W'(tail_reg) + RING_W'(1);
    assign nt      = (nt_wide >= cfg.ring) ? '0 : nt_wide[IW-1:0];
    assign nh_wide = RING_W'(nt) + RING_W'(1);
    assign nh      = (nh_wide >= cfg.ring) ? '0 : nh_wide[IW-1:0];

    assign can_load = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        tail_next      = tail_reg;
        head_next      = head_reg;
        offset_next    = offset_reg;
        blank_next     = blank_reg;
        adv_next       = adv_reg;
        out_valid_next = out_valid_reg;
        kind_next      = kind_reg;
        sel_next       = sel_reg;
        addr_next      = addr_reg;
        count_next     = count_reg;
        too_long_next  = too_long_reg;
        last_next      = last_reg;
        pop            = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CHECK:
            begin
                if (head.valid)
                begin
                    if (head.too_long)
                    begin
                        if (can_load)
                        begin
                            out_valid_next = 1'b1;
                            kind_next      = CMD_WRITE;
                            sel_next       = 2'd0;
                            addr_next      = '0;
                            count_next     = '0;
                            too_long_next  = 1'b1;
                            last_next      = 1'b1;
                            pop            = 1'b1;
                        end
                    end
                    else if (!fits && adv_reg != AW'(LIMIT))
                    begin
                        if (nt == head_reg)
                        begin
                            offset_next[nt] = '0;
                            blank_next[nt]  = 1'b0;
                            head_next       = nh;
                        end
                        tail_next = nt;
                        adv_next  = adv_reg + AW'(1);
                    end
                    else if (can_load)
                    begin
                        out_valid_next = 1'b1;
                        sel_next       = tail_ext[1:0];
                        too_long_next  = 1'b0;
                        if (cur_off == '0 && !blank_reg[tail_reg])
                        begin
                            kind_next            = CMD_ERASE;
                            addr_next            = '0;
                            count_next           = '0;
                            last_next            = 1'b0;
                            blank_next[tail_reg] = 1'b1;
                            state_next           = ST_WRITE;
                        end
                        else
                        begin
                            kind_next  = CMD_WRITE;
                            addr_next  = cur_desc[ADDR_W-1:0] + ADDR_W'(cur_off);
                            count_next = head.cnt;
                            last_next  = 1'b1;
                            offset_next[tail_reg] = cur_off + OFFSET_BITS'(head.cnt);
                            blank_next[tail_reg]  = 1'b0;
                            adv_next   = '0;
                            pop        = 1'b1;
                        end
                    end
                end
            end
            ST_WRITE:
            begin
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = CMD_WRITE;
                    sel_next       = tail_ext[1:0];
                    addr_next      = cur_desc[ADDR_W-1:0] + ADDR_W'(cur_off);
                    count_next     = head.cnt;
                    too_long_next  = 1'b0;
                    last_next      = 1'b1;
                    offset_next[tail_reg] = cur_off + OFFSET_BITS'(head.cnt);
                    blank_next[tail_reg]  = 1'b0;
                    adv_next       = '0;
                    pop            = 1'b1;
                    state_next     = ST_CHECK;
                end
            end
            default:
            begin
                state_next = ST_CHECK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CHECK;
            tail_reg      <= '0;
            head_reg      <= '0;
            offset_reg    <= '0;
            blank_reg     <= '0;
            adv_reg       <= '0;
            out_valid_reg <= 1'b0;
            kind_reg      <= CMD_WRITE;
            sel_reg       <= '0;
            addr_reg      <= '0;
            count_reg     <= '0;
            too_long_reg  <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tail_reg      <= tail_next;
            head_reg      <= head_next;
            offset_reg    <= offset_next;
            blank_reg     <= blank_next;
            adv_reg       <= adv_next;
            out_valid_reg <= out_valid_next;
            kind_reg      <= kind_next;
            sel_reg       <= sel_next;
            addr_reg      <= addr_next;
            count_reg     <= count_next;
            too_long_reg  <= too_long_next;
            last_reg      <= last_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign cmd_kind   = kind_reg;
    assign sector_sel = sel_reg;
    assign write_addr = addr_reg;
    assign byte_count = count_reg;
    assign too_long   = too_long_reg;
    assign last       = last_reg;

endmodule

### bench/tb_flash_sector_ring_log_appender.sv
module tb_flash_sector_ring_log_appender;

    import fsrla_pkg::*;

    // The block is built with four sectors and 18-bit offsets; the local copy of the
    // ring below uses the same sizes.
    localparam int MAX_SEC     = 4;
    localparam int OFF_W       = 18;
    localparam int LONG_HOLD   = 300;
    localparam int QUIET_LIMIT = 4000;
    localparam int RAND_PHASES = 11;
    localparam int PHASE_ITEMS = 145;
    localparam int PRINT_CAP   = 40;

    // One flash command word as it leaves the block.
    typedef struct {
        cmd_kind_t         kind;
        logic [1:0]        sel;
        logic [ADDR_W-1:0] addr;
        logic [CNT_W-1:0]  cnt;
        logic              too_long;
        logic              last;
    } flash_cmd_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DESC_W-1:0]    cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [REC_W-1:0]     record_len = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic                 cmd_kind;
    logic [1:0]           sector_sel;
    logic [ADDR_W-1:0]    write_addr;
    logic [CNT_W-1:0]     byte_count;
    logic                 too_long;
    logic                 last;

    flash_sector_ring_log_appender #(
        .MAX_SECTORS(MAX_SEC),
        .OFFSET_BITS(OFF_W)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .record_len(record_len),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .cmd_kind(cmd_kind),
        .sector_sel(sector_sel),
        .write_addr(write_addr),
        .byte_count(byte_count),
        .too_long(too_long),
        .last(last)
    );

    always #2 clk = ~clk;

    // Records waiting to be offered, and the command words the ring owes us.
    logic [REC_W-1:0] record_backlog [$];
    flash_cmd_t       cmd_expect_q [$];

    // Shadow copy of the ring: configuration, head and tail, per-sector fill level and
    // the mark telling that a sector is known to be erased.
    logic [SIU_W-1:0]  ring_cfg;
    logic [DESC_W-1:0] desc_cfg [NUM_DESC];
    int unsigned       head_sec;
    int unsigned       tail_sec;
    logic [OFF_W-1:0]  sec_off [MAX_SEC];
    bit                sec_blank [MAX_SEC];

    // Knobs set by the sequence in the initial block and read by the clocked processes.
    bit idle_on = 1'b0;
    int hold_requests = 0;

    int fail_cnt = 0;
    int send_gap = 0;
    int stall_left = 0;
    int hold_left = 0;
    int holds_done = 0;
    int quiet_cycles = 0;

    function automatic flash_cmd_t make_cmd(input cmd_kind_t kind, input logic [1:0] sel,
                                            input logic [ADDR_W-1:0] addr,
                                            input logic [CNT_W-1:0] cnt,
                                            input logic tl, input logic lst);
        flash_cmd_t word;
        word.kind     = kind;
        word.sel      = sel;
        word.addr     = addr;
        word.cnt      = cnt;
        word.too_long = tl;
        word.last     = lst;
        return word;
    endfunction

    function automatic int unsigned sector_length(input int unsigned s);
        return int'(desc_cfg[s][DESC_W-1:ADDR_W]);
    endfunction

    function automatic logic [DESC_W-1:0] desc_word(input logic [LEN_W-1:0] slen,
                                                    input logic [ADDR_W-1:0] base);
        return {slen, base};
    endfunction

    // Works out the command words for one append and moves the shadow ring along.
    function automatic void predict_append(input logic [REC_W-1:0] rlen);
        int unsigned n;
        int unsigned need;
        int unsigned nt;
        int unsigned nh;
        bit fits;
        logic [ADDR_W-1:0] addr;
        n = (ring_cfg == 0) ? 1 : ((ring_cfg > MAX_SEC) ? MAX_SEC : int'(ring_cfg));
        need = int'(rlen) + 1;

        // A record must fit strictly inside at least one sector of the ring when written
        // from offset zero; otherwise it is flagged and the ring is left alone.
        fits = 1'b0;
        for (int s = 0; s < n; s++)
            if (need < sector_length(s))
                fits = 1'b1;
        if (!fits) begin
            cmd_expect_q.push_back(make_cmd(CMD_WRITE, 2'd0, '0, '0, 1'b1, 1'b1));
            return;
        end

        // Move the tail on until the record fits, giving up after 2 * MAX_SEC steps. Landing on
        // the head recycles that sector and pushes the head one further.
        for (int k = 0; k < 2 * MAX_SEC; k++) begin
            if (sec_off[tail_sec] + need < sector_length(tail_sec))
                break;
            nt = tail_sec + 1;
            if (nt >= n)
                nt = 0;
            if (nt == head_sec) begin
                nh = nt + 1;
                if (nh >= n)
                    nh = 0;
                sec_off[nt] = '0;
                sec_blank[nt] = 1'b0;
                head_sec = nh;
            end
            tail_sec = nt;
        end

        // Starting a sector that is not known to be erased costs an erase first.
        if (sec_off[tail_sec] == 0 && !sec_blank[tail_sec]) begin
            cmd_expect_q.push_back(make_cmd(CMD_ERASE, 2'(tail_sec), '0, '0, 1'b0, 1'b0));
            sec_blank[tail_sec] = 1'b1;
        end

        addr = desc_cfg[tail_sec][ADDR_W-1:0] + sec_off[tail_sec];
        cmd_expect_q.push_back(make_cmd(CMD_WRITE, 2'(tail_sec), addr, CNT_W'(need),
                                        1'b0, 1'b1));
        sec_off[tail_sec] = OFF_W'(sec_off[tail_sec] + need);
        sec_blank[tail_sec] = 1'b0;
    endfunction

    function automatic void report_field(input string field, input logic [ADDR_W-1:0] want_v,
                                         input logic [ADDR_W-1:0] got_v);
        fail_cnt++;
        if (fail_cnt <= PRINT_CAP)
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want_v,
                     got_v);
    endfunction

    // Sender: offers records from the backlog, holds each one until it is taken, and
    // now and then, while idling is on, leaves a gap before the next record.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            record_len <= '0;
            send_gap <= 0;
        end else begin
            if (in_valid && in_ready)
                predict_append(record_len);
            if (!in_valid || in_ready) begin
                if (send_gap != 0) begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end else if (record_backlog.size() != 0) begin
                    in_valid <= 1'b1;
                    record_len <= record_backlog.pop_front();
                    if (idle_on && $urandom_range(0, 7) == 0)
                        send_gap <= $urandom_range(1, 17);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks every accepted command word against the oldest expectation. Its
    // ready drops in random bursts, and on request it holds off for a long
    // stretch so that the queue inside the block fills and the input stalls.
    always @(posedge clk or negedge rst_n) begin : receiver_proc
        flash_cmd_t got;
        flash_cmd_t want;
        if (!rst_n) begin
            out_ready <= 1'b0;
            stall_left <= 0;
            hold_left <= 0;
            holds_done <= 0;
        end else begin
            if (out_valid && out_ready) begin
                got = make_cmd(cmd_kind_t'(cmd_kind), sector_sel, write_addr, byte_count,
                               too_long, last);
                if (cmd_expect_q.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= PRINT_CAP)
                        $display("%0t: word with none expected, actual kind %0d sector %0d",
                                 $time, got.kind, got.sel, " addr %0h count %0d",
                                 got.addr, got.cnt, " too_long %0d last %0d",
                                 got.too_long, got.last);
                end else begin
                    want = cmd_expect_q.pop_front();
                    if (got.kind !== want.kind)
                        report_field("cmd_kind", ADDR_W'(want.kind), ADDR_W'(got.kind));
                    if (got.sel !== want.sel)
                        report_field("sector_sel", ADDR_W'(want.sel), ADDR_W'(got.sel));
                    if (got.addr !== want.addr)
                        report_field("write_addr", want.addr, got.addr);
                    if (got.cnt !== want.cnt)
                        report_field("byte_count", ADDR_W'(want.cnt), ADDR_W'(got.cnt));
                    if (got.too_long !== want.too_long)
                        report_field("too_long", ADDR_W'(want.too_long),
                                     ADDR_W'(got.too_long));
                    if (got.last !== want.last)
                        report_field("last", ADDR_W'(want.last), ADDR_W'(got.last));
                end
            end

            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end else if (holds_done != hold_requests) begin
                holds_done <= hold_requests;
                hold_left <= LONG_HOLD;
                out_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                out_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                stall_left <= $urandom_range(0, 16);
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Watchdog: a long run of cycles in which no word moves on any port means a hang.
    always @(posedge clk) begin
        if (rst_n && !((in_valid && in_ready) || (out_valid && out_ready) || cfg_write)) begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end else begin
            quiet_cycles <= 0;
        end
    end

    // Register writes go straight to the port; the shadow copy follows once the write
    // has landed, which is safe since nothing is in flight while we configure.
    task automatic write_reg(input reg_index_t idx, input logic [DESC_W-1:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == REG_SECTORS_IN_USE)
            ring_cfg = val[SIU_W-1:0];
        else
            desc_cfg[idx - REG_SECTOR_DESC_0] = val;
    endtask

    // Waits until every record has been taken and every command word has come back,
    // then lets the block settle.
    task automatic drain_appends();
        do
            @(negedge clk);
        while (record_backlog.size() != 0 || in_valid || cmd_expect_q.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic offer(input logic [REC_W-1:0] rlen);
        record_backlog.push_back(rlen);
    endtask

    // Picks a new ring. Most sectors are 2 to 1200 bytes long so that the tail wraps
    // often; some are too short for most records, a few are long or at the top of the
    // address space. Outside the first random phase only some registers are rewritten.
    task automatic shuffle_ring(input bit all_regs);
        logic [LEN_W-1:0]  slen;
        logic [ADDR_W-1:0] sbase;
        int unsigned       pick;
        pick = $urandom_range(0, 9);
        write_reg(REG_SECTORS_IN_USE,
                  DESC_W'((pick < 7) ? $urandom_range(1, 4) : $urandom_range(0, 7)));
        for (int i = 0; i < NUM_DESC; i++) begin
            if (all_regs || $urandom_range(0, 2) != 0) begin
                pick = $urandom_range(0, 19);
                if (pick < 13)
                    slen = LEN_W'($urandom_range(2, 1200));
                else if (pick < 17)
                    slen = LEN_W'($urandom_range(0, 260));
                else if (pick < 19)
                    slen = LEN_W'($urandom_range(1200, 4000));
                else
                    slen = LEN_W'($urandom);
                if ($urandom_range(0, 3) == 0)
                    sbase = 32'hFFFF_FFFF - $urandom_range(0, 1023);
                else
                    sbase = $urandom;
                write_reg(reg_index_t'(REG_SECTOR_DESC_0 + i), desc_word(slen, sbase));
            end
        end
    endtask

    initial begin
        int unsigned pick;

        // Shadow state after reset: four sectors, all descriptors zero, nothing blank.
        ring_cfg = 3'd4;
        head_sec = 0;
        tail_sec = 0;
        for (int s = 0; s < MAX_SEC; s++) begin
            desc_cfg[s] = '0;
            sec_off[s] = '0;
            sec_blank[s] = 1'b0;
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // With every sector of zero length nothing fits, even an empty record.
        @(negedge clk);
        offer(8'd0);
        offer(8'd255);
        drain_appends();

        // A mixed ring: a normal sector, one that holds only an empty record, one near
        // the top of the address space and one of maximum length whose base is all ones,
        // so writes there wrap the address. Records fill sector 0, skip sector 1 and
        // then erase and fill the others.
        write_reg(REG_SECTORS_IN_USE, DESC_W'(4));
        write_reg(REG_SECTOR_DESC_0, desc_word(18'd300, 32'h0000_1000));
        write_reg(REG_SECTOR_DESC_1, desc_word(18'd2, 32'hFFFF_FF80));
        write_reg(REG_SECTOR_DESC_2, desc_word(18'd600, 32'hFFFF_FF00));
        write_reg(REG_SECTOR_DESC_3, {DESC_W{1'b1}});
        @(negedge clk);
        offer(8'd0);
        offer(8'd255);
        offer(8'd255);
        offer(8'd0);
        offer(8'd128);
        offer(8'd255);
        offer(8'd255);
        offer(8'd200);
        offer(8'd7);
        drain_appends();

        // A ring size of zero acts as one sector, and the tail now sits beyond the ring.
        // A 256-byte sector takes 254 but not 255, the boundary of the strict fit test.
        // In a one-sector ring every wrap lands on the head and forces a fresh erase.
        write_reg(REG_SECTORS_IN_USE, DESC_W'(0));
        write_reg(REG_SECTOR_DESC_0, desc_word(18'd256, 32'h0000_0000));
        write_reg(REG_SECTOR_DESC_3, desc_word(18'd0, 32'h0000_0000));
        @(negedge clk);
        offer(8'd255);
        offer(8'd254);
        offer(8'd254);
        offer(8'd0);
        drain_appends();

        // A ring size above four is clipped to four.
        write_reg(REG_SECTORS_IN_USE, DESC_W'(7));
        write_reg(REG_SECTOR_DESC_1, desc_word(18'd1000, 32'h8000_0000));
        @(negedge clk);
        offer(8'd100);
        offer(8'd255);
        drain_appends();

        // Random phases. Between phases the sequence waits for every command word before
        // the ring is changed. Phase 2 carries the long receiver hold-off; some phases
        // and the final two run with no idling at all.
        for (int p = 0; p < RAND_PHASES; p++) begin
            shuffle_ring(p == 0);
            @(negedge clk);
            idle_on = (p < RAND_PHASES - 2) && (p % 4 != 1);
            if (p == 2)
                hold_requests = hold_requests + 1;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                pick = $urandom_range(0, 9);
                if (pick < 7)
                    offer(REC_W'($urandom_range(0, 255)));
                else if (pick < 9)
                    offer(REC_W'($urandom_range(0, 15)));
                else
                    offer(REC_W'($urandom_range(250, 255)));
            end
            drain_appends();
        end

        repeat (20) @(posedge clk);
        if (fail_cnt == 0 && cmd_expect_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
